/* rtl/lxc_pkg.sv */
// ----------------------------------------------------------------------------
// lxc_pkg
// shared types and constants of the lfsr xor keystream cipher
// ----------------------------------------------------------------------------
package lxc_pkg;

    localparam int unsigned DataWidth    = 8;
    localparam int unsigned LfsrWidth    = 32;
    localparam int unsigned PatternWidth = 64;
    localparam int unsigned IndexWidth   = 6;
    localparam int unsigned CfgIdxWidth  = 2;
    localparam int unsigned CfgDataWidth = 64;

    localparam logic [DataWidth-1:0]  KeyPoly       = 8'h21;
    localparam logic [LfsrWidth-1:0]  RstLfsrStart  = 32'h0000_0084;
    localparam logic [DataWidth-1:0]  RstKeyStart   = 8'hef;
    localparam logic [LfsrWidth-1:0]  RstTapMask    = 32'h0000_e03e;
    localparam logic [PatternWidth-1:0] RstPattern  = 64'h0;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_LFSR_START    = 2'd0,
        CFG_KEY_START     = 2'd1,
        CFG_TAP_MASK      = 2'd2,
        CFG_FORCED_PATTERN = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [LfsrWidth-1:0]    lfsr_start;
        logic [DataWidth-1:0]    key_start;
        logic [LfsrWidth-1:0]    tap_mask;
        logic [PatternWidth-1:0] forced_pattern;
    } cfg_t;

endpackage

/* rtl/lxc_cfg.sv */
// ----------------------------------------------------------------------------
// lxc_cfg
// configuration register file, write only
// ----------------------------------------------------------------------------
module lxc_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lxc_pkg::CfgIdxWidth-1:0]     cfg_index,
    input  logic [lxc_pkg::CfgDataWidth-1:0]    cfg_data,
    output lxc_pkg::cfg_t                       cfg
);
    import lxc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_LFSR_START:     cfg_next.lfsr_start     = cfg_data[LfsrWidth-1:0];
                CFG_KEY_START:      cfg_next.key_start      = cfg_data[DataWidth-1:0];
                CFG_TAP_MASK:       cfg_next.tap_mask       = cfg_data[LfsrWidth-1:0];
                CFG_FORCED_PATTERN: cfg_next.forced_pattern = cfg_data[PatternWidth-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lfsr_start     <= RstLfsrStart;
            cfg_reg.key_start      <= RstKeyStart;
            cfg_reg.tap_mask       <= RstTapMask;
            cfg_reg.forced_pattern <= RstPattern;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/lxc_ks.sv */
// ----------------------------------------------------------------------------
// lxc_ks
// keystream state: lfsr, key byte and bit counter, one step per byte
// ----------------------------------------------------------------------------
module lxc_ks (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  logic                             restart,
    input  lxc_pkg::cfg_t                    cfg,
    output logic [lxc_pkg::DataWidth-1:0]    key_use
);
    import lxc_pkg::*;

    logic [LfsrWidth-1:0]  lfsr_reg;
    logic [LfsrWidth-1:0]  lfsr_next;
    logic [DataWidth-1:0]  key_reg;
    logic [DataWidth-1:0]  key_next;
    logic [IndexWidth-1:0] index_reg;
    logic [IndexWidth-1:0] index_next;

    logic [LfsrWidth-1:0]  lfsr_cur;
    logic [DataWidth-1:0]  key_cur;
    logic [IndexWidth-1:0] index_cur;
    logic                  forced;
    logic                  fb;

    always_comb
    begin
        lfsr_cur  = restart ? cfg.lfsr_start : lfsr_reg;
        key_cur   = restart ? cfg.key_start : key_reg;
        index_cur = restart ? '0 : index_reg;
        forced    = |cfg.forced_pattern;
        fb        = forced ? cfg.forced_pattern[index_cur] : lfsr_cur[0];

        if (forced)
            lfsr_next = lfsr_cur;
        else
            lfsr_next = {1'b0, lfsr_cur[LfsrWidth-1:1]} ^ (fb ? cfg.tap_mask : '0);

        key_next   = {key_cur[DataWidth-2:0], 1'b0}
                   ^ ((fb ^ key_cur[DataWidth-1]) ? KeyPoly : '0);
        index_next = index_cur + IndexWidth'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg  <= RstLfsrStart;
            key_reg   <= RstKeyStart;
            index_reg <= '0;
        end
        else if (step)
        begin
            lfsr_reg  <= lfsr_next;
            key_reg   <= key_next;
            index_reg <= index_next;
        end
    end

    assign key_use = key_cur;

endmodule

/* rtl/lfsr_xor_keystream_cipher.sv */
// ----------------------------------------------------------------------------
// lfsr_xor_keystream_cipher
// byte-wise xor stream cipher keyed by a galois lfsr or a forced bit pattern
//
//   channel   dir   handshake           payload
//   s_*       in    s_tvalid/s_tready   s_tdata = data_in, s_tuser = restart
//   m_*       out   m_tvalid/m_tready   m_tdata = data_out
//   cfg_*     in    cfg_we              cfg_index, cfg_data
//
// one byte per clock sustained while m_tready is high, via the input and result registers to the output
// the keystream steps when a byte moves from the input register to the result
// register; input register and result register each hold one byte
// a stall on m_tready fills both registers before s_tready drops
// reset loads the register reset values and the keystream start state
// ----------------------------------------------------------------------------
module lfsr_xor_keystream_cipher (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lxc_pkg::DataWidth-1:0]       s_tdata,   // data_in
    input  logic                                s_tuser,   // restart
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lxc_pkg::DataWidth-1:0]       m_tdata,   // data_out
    input  logic                                cfg_we,
    input  logic [lxc_pkg::CfgIdxWidth-1:0]     cfg_index,
    input  logic [lxc_pkg::CfgDataWidth-1:0]    cfg_data
);
    import lxc_pkg::*;

    cfg_t                 cfg;
    logic                 in_valid_reg;
    logic [DataWidth-1:0] in_data_reg;
    logic                 in_restart_reg;
    logic                 out_valid_reg;
    logic [DataWidth-1:0] out_data_reg;
    logic                 advance;
    logic                 s_xfer;
    logic [DataWidth-1:0] key_use;

    lxc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lxc_ks u_ks (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .restart (in_restart_reg),
        .cfg     (cfg),
        .key_use (key_use)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (!out_valid_reg || m_tready)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_data_reg    <= s_tdata;
            in_restart_reg <= s_tuser;
        end
        if (advance)
            out_data_reg <= in_data_reg ^ key_use;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the lfsr xor keystream cipher: a clocked driver feeds
// bytes from a queue, a local keystream model predicts every output byte, and
// a clocked monitor compares each output transfer against the oldest prediction
// under several key settings, forced patterns and idle/stall mixes
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lxc_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int HoldCycles = 400;
    localparam int RandPhases = 8;
    localparam int PhaseItems = 150;

    typedef struct packed {
        logic [DataWidth-1:0] data;
        logic                 restart;
    } byte_item_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [DataWidth-1:0]    s_tdata = '0;
    logic                    s_tuser = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [DataWidth-1:0]    m_tdata;
    logic                    cfg_we = 1'b0;
    cfg_idx_t                cfg_index = CFG_LFSR_START;
    logic [CfgDataWidth-1:0] cfg_data = '0;

    byte_item_t           byte_queue[$];
    logic [DataWidth-1:0] cipher_out_q[$];

    cfg_t                  cfg_shadow;
    logic [LfsrWidth-1:0]  ks_lfsr;
    logic [DataWidth-1:0]  ks_key;
    logic [IndexWidth-1:0] ks_index;

    int fail_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit long_hold = 1'b0;
    int hold_count = 0;

    lfsr_xor_keystream_cipher uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // data_in
        .s_tuser   (s_tuser),   // restart
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // data_out
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [DataWidth-1:0] cipher_step(logic [DataWidth-1:0] din,
                                                         logic rs);
        logic [DataWidth-1:0] dout;
        logic                 carry;
        logic                 fb;
        if (rs)
        begin
            ks_lfsr  = cfg_shadow.lfsr_start;
            ks_key   = cfg_shadow.key_start;
            ks_index = '0;
        end
        dout   = din ^ ks_key;
        carry  = ks_key[DataWidth-1];
        ks_key = {ks_key[DataWidth-2:0], 1'b0};
        if (cfg_shadow.forced_pattern != '0)
            fb = cfg_shadow.forced_pattern[ks_index];
        else
        begin
            fb      = ks_lfsr[0];
            ks_lfsr = ks_lfsr >> 1;
            if (fb)
                ks_lfsr = ks_lfsr ^ cfg_shadow.tap_mask;
        end
        ks_index = ks_index + 1'b1;
        if (fb ^ carry)
            ks_key = ks_key ^ KeyPoly;
        return dout;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                cipher_out_q.push_back(cipher_step(s_tdata, s_tuser));
            if (!s_tvalid || s_tready)
            begin
                if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tdata  <= byte_queue[0].data;
                    s_tuser  <= byte_queue[0].restart;
                    s_tvalid <= 1'b1;
                    void'(byte_queue.pop_front());
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor and receiver
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (cipher_out_q.size() == 0)
                begin
                    $error("data_out: unexpected transfer, expected none, actual %02h",
                           m_tdata);
                    fail_count++;
                end
                else
                begin
                    if (m_tdata !== cipher_out_q[0])
                    begin
                        $error("data_out mismatch: expected %02h, actual %02h",
                               cipher_out_q[0], m_tdata);
                        fail_count++;
                    end
                    void'(cipher_out_q.pop_front());
                end
            end
            if (long_hold && hold_count < HoldCycles)
            begin
                m_tready   <= 1'b0;
                hold_count <= hold_count + 1;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_cfg(cfg_idx_t idx, logic [CfgDataWidth-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_LFSR_START:     cfg_shadow.lfsr_start     = value[LfsrWidth-1:0];
            CFG_KEY_START:      cfg_shadow.key_start      = value[DataWidth-1:0];
            CFG_TAP_MASK:       cfg_shadow.tap_mask       = value[LfsrWidth-1:0];
            CFG_FORCED_PATTERN: cfg_shadow.forced_pattern = value;
            default: ;
        endcase
    endtask

    task automatic load_setting(logic [LfsrWidth-1:0] lfsr, logic [DataWidth-1:0] key,
                                logic [LfsrWidth-1:0] taps,
                                logic [PatternWidth-1:0] pattern);
        write_cfg(CFG_LFSR_START, CfgDataWidth'(lfsr));
        write_cfg(CFG_KEY_START, CfgDataWidth'(key));
        write_cfg(CFG_TAP_MASK, CfgDataWidth'(taps));
        write_cfg(CFG_FORCED_PATTERN, pattern);
    endtask

    task automatic push_byte(logic [DataWidth-1:0] data, logic restart);
        byte_item_t item;
        item.data    = data;
        item.restart = restart;
        byte_queue.push_back(item);
    endtask

    // checked between edges so that driver and monitor updates have settled
    task automatic wait_drained();
        while (byte_queue.size() != 0 || s_tvalid || cipher_out_q.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        logic [LfsrWidth-1:0]    lfsr;
        logic [DataWidth-1:0]    key;
        logic [LfsrWidth-1:0]    taps;
        logic [PatternWidth-1:0] pattern;
        logic [DataWidth-1:0]    data;
        int                      run_left;
        logic                    rs;

        cfg_shadow.lfsr_start     = RstLfsrStart;
        cfg_shadow.key_start      = RstKeyStart;
        cfg_shadow.tap_mask       = RstTapMask;
        cfg_shadow.forced_pattern = RstPattern;
        ks_lfsr  = RstLfsrStart;
        ks_key   = RstKeyStart;
        ks_index = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset state, no restart first
        push_byte(8'h00, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(8'ha5, 1'b0);
        push_byte(8'h5a, 1'b1);
        push_byte(8'hff, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h3c, 1'b0);
        wait_drained();

        // zero lfsr and zero taps
        load_setting('0, '0, '0, '0);
        push_byte(8'hff, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(8'h81, 1'b0);
        wait_drained();

        load_setting('1, '1, '1, '0);
        push_byte(8'h00, 1'b1);
        push_byte(8'hff, 1'b0);
        push_byte(8'h55, 1'b0);
        push_byte(8'haa, 1'b0);
        wait_drained();

        // forced mode, running state kept across the write
        write_cfg(CFG_FORCED_PATTERN, '1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hff, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hff, 1'b0);
        wait_drained();

        write_cfg(CFG_FORCED_PATTERN, 64'h8000_0000_0000_0001);
        push_byte(8'h00, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hff, 1'b0);
        wait_drained();

        for (int p = 0; p < RandPhases; p++)
        begin
            lfsr    = (p == 0) ? '0 : (p == 1) ? '1 : $urandom;
            key     = (p == 0) ? '0 : (p == 1) ? '1 : DataWidth'($urandom);
            taps    = (p == 2) ? '0 : (p == 1) ? '1 : $urandom;
            pattern = '0;
            case (p)
                3: pattern = '1;
                5: pattern = {$urandom, $urandom};
                6: pattern = 64'h8000_0000_0000_0000;
                7: pattern = 64'h1;
                default: ;
            endcase
            load_setting(lfsr, key, taps, pattern);

            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            if (p == 4)
                long_hold = 1'b1;

            run_left = 0;
            for (int i = 0; i < PhaseItems; i++)
            begin
                rs = 1'b0;
                if (run_left == 0 || $urandom_range(49) == 0)
                begin
                    rs       = 1'b1;
                    run_left = $urandom_range(120, 1);
                end
                run_left--;
                case ($urandom_range(9))
                    0: data = '0;
                    1: data = '1;
                    default: data = DataWidth'($urandom);
                endcase
                push_byte(data, rs);
            end
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0 && cipher_out_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
